>>> src/hall_six_step_commutator_assert.svh
// Assertion macros shared by the RTL; all sample on clk and are gated off in reset.
`ifndef HALL_SIX_STEP_COMMUTATOR_ASSERT_SVH
`define HALL_SIX_STEP_COMMUTATOR_ASSERT_SVH

// cond must hold at every clock edge
`define HSSC_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// cons must hold at the edge after one where ante holds
`define HSSC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/hssc_pkg.sv
package hssc_pkg;

	localparam int PERIOD_TICKS_DEF = 2000;
	localparam int TIMER_BITS_DEF   = 16;

	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DUTY_CAP    = 2'd0,
		REG_REVERSE_DIR = 2'd1,
		REG_KICK_MS     = 2'd2,
		REG_STALL_MS    = 2'd3
	} reg_idx_t;

	localparam logic [10:0] DUTY_CAP_RST = 11'd250;
	localparam logic [15:0] KICK_MS_RST  = 16'd200;
	localparam logic [15:0] STALL_MS_RST = 16'd1000;

	typedef struct packed {
		logic [10:0] duty_cap;
		logic        reverse_dir;
		logic [15:0] kick_ms;
		logic [15:0] stall_ms;
	} cfg_t;

	typedef struct packed {
		logic [2:0] hall_code;
		logic       bridge_fault;
		logic       ms_tick;
	} item_t;

	typedef struct packed {
		logic [26:0] gate_word_one;
		logic [10:0] gate_word_two;
		logic [10:0] duty_ticks;
		logic [2:0]  drive_step;
		logic [1:0]  mode;
		logic [1:0]  fault_cause;
		logic        commutated;
	} res_t;

	// Hall code to commutation step; codes 0 and 7 are illegal
	function automatic logic [2:0] hall_step(input logic [2:0] code);
		logic [2:0] s;
		unique case (code)
			3'd2:    s = 3'd2;
			3'd3:    s = 3'd1;
			3'd4:    s = 3'd4;
			3'd5:    s = 3'd5;
			3'd6:    s = 3'd3;
			default: s = 3'd0;
		endcase
		return s;
	endfunction

	function automatic logic [26:0] word_one(input logic [2:0] step);
		logic [26:0] w;
		unique case (step)
			3'd0:    w = 27'h0030500;
			3'd1:    w = 27'h0030100;
			3'd2:    w = 27'h3000001;
			3'd3:    w = 27'h3000005;
			3'd4:    w = 27'h0000005;
			3'd5:    w = 27'h0000500;
			default: w = 27'h0000000;
		endcase
		return w;
	endfunction

	function automatic logic [10:0] word_two(input logic [2:0] step);
		logic [10:0] w;
		unique case (step)
			3'd0:    w = 11'h001;
			3'd1:    w = 11'h005;
			3'd2:    w = 11'h005;
			3'd3:    w = 11'h001;
			3'd4:    w = 11'h300;
			3'd5:    w = 11'h300;
			default: w = 11'h000;
		endcase
		return w;
	endfunction

endpackage

>>> src/hssc_in_if.sv
interface hssc_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] hall_code;
	logic       bridge_fault;
	logic       ms_tick;

	modport source(output valid, hall_code, bridge_fault, ms_tick, input ready);
	modport sink(input valid, hall_code, bridge_fault, ms_tick, output ready);
endinterface

>>> src/hssc_out_if.sv
interface hssc_out_if;
	logic        valid;
	logic        ready;
	logic [26:0] gate_word_one;
	logic [10:0] gate_word_two;
	logic [10:0] duty_ticks;
	logic [2:0]  drive_step;
	logic [1:0]  mode;
	logic [1:0]  fault_cause;
	logic        commutated;

	modport source(output valid, gate_word_one, gate_word_two, duty_ticks, drive_step, mode,
		fault_cause, commutated, input ready);
	modport sink(input valid, gate_word_one, gate_word_two, duty_ticks, drive_step, mode,
		fault_cause, commutated, output ready);
endinterface

>>> src/hssc_cfg.sv
module hssc_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [hssc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hssc_pkg::CFG_DATA_W-1:0] cfg_data,
	output hssc_pkg::cfg_t                   cfg
);

	hssc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.duty_cap    <= hssc_pkg::DUTY_CAP_RST;
			cfg_q.reverse_dir <= 1'b0;
			cfg_q.kick_ms     <= hssc_pkg::KICK_MS_RST;
			cfg_q.stall_ms    <= hssc_pkg::STALL_MS_RST;
		end else if (cfg_we) begin
			unique case (hssc_pkg::reg_idx_t'(cfg_index))
				hssc_pkg::REG_DUTY_CAP:    cfg_q.duty_cap    <= cfg_data[10:0];
				hssc_pkg::REG_REVERSE_DIR: cfg_q.reverse_dir <= cfg_data[0];
				hssc_pkg::REG_KICK_MS:     cfg_q.kick_ms     <= cfg_data[15:0];
				hssc_pkg::REG_STALL_MS:    cfg_q.stall_ms    <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> src/hssc_core.sv
`include "hall_six_step_commutator_assert.svh"

module hssc_core #(
	parameter int PERIOD_TICKS = hssc_pkg::PERIOD_TICKS_DEF,
	parameter int TIMER_BITS   = hssc_pkg::TIMER_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  hssc_pkg::item_t item,
	input  hssc_pkg::cfg_t  cfg,
	output hssc_pkg::res_t  res
);

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_KICK  = 2'd1,
		MODE_RUN   = 2'd2,
		MODE_LATCH = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		CAUSE_NONE   = 2'd0,
		CAUSE_HALL   = 2'd1,
		CAUSE_STALL  = 2'd2,
		CAUSE_BRIDGE = 2'd3
	} cause_t;

	localparam logic [32:0] TMAX   = (33'd1 << TIMER_BITS) - 33'd1;
	localparam logic [32:0] PERIOD = 33'(PERIOD_TICKS);
	localparam logic [32:0] LIMIT  = (PERIOD < TMAX) ? PERIOD : TMAX;

	mode_t       mode_q, mode_d;
	cause_t      cause_q, cause_d;
	logic [2:0]  prev_q;
	logic        seen_q;
	logic [2:0]  acc_q, acc_d;
	logic [15:0] ms_q, ms_d;
	logic [2:0]  step_q, step_d;

	logic        stable, legal, did, commute, drive;
	logic [15:0] ms_inc, ms_chk;
	logic [2:0]  base_step, new_step;
	logic [10:0] duty;

	always_comb begin
		stable    = seen_q && (item.hall_code == prev_q);
		legal     = (item.hall_code != 3'd0) && (item.hall_code != 3'd7);
		ms_inc    = (item.ms_tick && ms_q != 16'hFFFF) ? ms_q + 16'd1 : ms_q;
		base_step = hssc_pkg::hall_step(item.hall_code);
		if (cfg.reverse_dir)
			new_step = (base_step >= 3'd3) ? base_step - 3'd3 : base_step + 3'd3;
		else
			new_step = base_step;

		mode_d  = mode_q;
		cause_d = cause_q;
		acc_d   = acc_q;
		ms_d    = ms_q;
		step_d  = step_q;
		did     = 1'b0;
		commute = 1'b0;
		ms_chk  = ms_inc;

		unique case (mode_q)
			MODE_IDLE: begin
				if (item.bridge_fault) begin
					mode_d  = MODE_LATCH;
					cause_d = CAUSE_BRIDGE;
				end else if (stable) begin
					if (!legal) begin
						mode_d  = MODE_LATCH;
						cause_d = CAUSE_HALL;
					end else begin
						acc_d  = item.hall_code;
						step_d = new_step;
						did    = 1'b1;
						mode_d = MODE_KICK;
						ms_d   = 16'd0;
					end
				end
			end
			MODE_KICK: begin
				ms_d = ms_inc;
				if (ms_inc >= cfg.kick_ms) begin
					mode_d = MODE_RUN;
					ms_d   = 16'd0;
				end
			end
			MODE_RUN: begin
				ms_d = ms_inc;
				if (stable && !legal) begin
					mode_d  = MODE_LATCH;
					cause_d = CAUSE_HALL;
				end else begin
					commute = stable && (item.hall_code != acc_q);
					if (commute) begin
						acc_d  = item.hall_code;
						step_d = new_step;
						did    = 1'b1;
						ms_chk = 16'd0;
						ms_d   = 16'd0;
					end
					if (ms_chk > cfg.stall_ms) begin
						mode_d  = MODE_LATCH;
						cause_d = CAUSE_STALL;
					end else if (item.bridge_fault) begin
						mode_d  = MODE_LATCH;
						cause_d = CAUSE_BRIDGE;
					end
				end
			end
			MODE_LATCH: ;
			default: ;
		endcase

		drive = (mode_d == MODE_KICK) || (mode_d == MODE_RUN);
		duty  = (33'(cfg.duty_cap) > LIMIT) ? LIMIT[10:0] : cfg.duty_cap;

		res.gate_word_one = drive ? hssc_pkg::word_one(step_d) : 27'd0;
		res.gate_word_two = drive ? hssc_pkg::word_two(step_d) : 11'd0;
		res.duty_ticks    = drive ? duty : 11'd0;
		res.drive_step    = step_d;
		res.mode          = mode_d;
		res.fault_cause   = cause_d;
		res.commutated    = did;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			cause_q <= CAUSE_NONE;
			prev_q  <= 3'd0;
			seen_q  <= 1'b0;
			acc_q   <= 3'd0;
			ms_q    <= 16'd0;
			step_q  <= 3'd0;
		end else if (advance) begin
			mode_q  <= mode_d;
			cause_q <= cause_d;
			prev_q  <= item.hall_code;
			seen_q  <= 1'b1;
			acc_q   <= acc_d;
			ms_q    <= ms_d;
			step_q  <= step_d;
		end
	end

	`HSSC_ASSERT_NEXT(a_latch_sticks, mode_q == MODE_LATCH, mode_q == MODE_LATCH,
		"latched mode left without reset")
	`HSSC_ASSERT_ALWAYS(a_cause_iff_latch,
		(mode_q == MODE_LATCH) == (cause_q != CAUSE_NONE),
		"fault cause disagrees with latched mode")
	`HSSC_ASSERT_NEXT(a_run_entry_clears,
		advance && mode_q == MODE_KICK && mode_d == MODE_RUN, ms_q == 16'd0,
		"millisecond count not cleared on entry to running")
	`HSSC_ASSERT_ALWAYS(a_commute_drives,
		!(advance && did) || mode_d == MODE_KICK || mode_d == MODE_RUN,
		"commutation outside a driving mode")
	`HSSC_ASSERT_ALWAYS(a_step_range, step_q <= 3'd5, "step index out of range")

endmodule

>>> src/hall_six_step_commutator.sv
// Channel   Dir  Payload                                     Handshake
// hall_in   in   hall_code, bridge_fault, ms_tick            valid/ready
// result    out  gate words, duty, step, mode, cause, flag   valid/ready
//
// One item per cycle sustained while result.ready stays high.
// Input register, then one pass of step logic into the result register.
// arst_n clears mode, sample history, counters and config registers to defaults; data registers are not reset.
// A result stall backs up into hall_in.ready only once both stages are full.
module hall_six_step_commutator #(
	parameter int PERIOD_TICKS = hssc_pkg::PERIOD_TICKS_DEF,
	parameter int TIMER_BITS   = hssc_pkg::TIMER_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	hssc_in_if.sink                          hall_in,
	hssc_out_if.source                       result,
	input  logic                             cfg_we,
	input  logic [hssc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hssc_pkg::CFG_DATA_W-1:0] cfg_data
);

	hssc_pkg::cfg_t  cfg;
	hssc_pkg::item_t item_s1;
	hssc_pkg::res_t  res, res_s2;
	logic            valid_s1, valid_s2, advance;

	hssc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hssc_core #(
		.PERIOD_TICKS (PERIOD_TICKS),
		.TIMER_BITS   (TIMER_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.res     (res)
	);

	assign advance       = valid_s1 && (!valid_s2 || result.ready);
	assign hall_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (hall_in.ready)
				valid_s1 <= hall_in.valid;
			if (advance)
				valid_s2 <= 1'b1;
			else if (result.ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (hall_in.valid && hall_in.ready) begin
			item_s1.hall_code    <= hall_in.hall_code;
			item_s1.bridge_fault <= hall_in.bridge_fault;
			item_s1.ms_tick      <= hall_in.ms_tick;
		end
		if (advance)
			res_s2 <= res;
	end

	assign result.valid         = valid_s2;
	assign result.gate_word_one = res_s2.gate_word_one;
	assign result.gate_word_two = res_s2.gate_word_two;
	assign result.duty_ticks    = res_s2.duty_ticks;
	assign result.drive_step    = res_s2.drive_step;
	assign result.mode          = res_s2.mode;
	assign result.fault_cause   = res_s2.fault_cause;
	assign result.commutated    = res_s2.commutated;

endmodule

>>> tb/sv/tb_hall_six_step_commutator.sv
module tb_hall_six_step_commutator;

	localparam int STALL_LIMIT = 2000;
	localparam logic [2:0] HALL_ALL_LOW  = 3'd0;
	localparam logic [2:0] HALL_ALL_HIGH = 3'd7;

	typedef enum logic [1:0] {MODE_IDLE, MODE_KICK, MODE_RUN, MODE_LATCHED} run_mode_t;
	typedef enum logic [1:0] {CAUSE_NONE, CAUSE_HALL, CAUSE_STALL, CAUSE_BRIDGE} cause_t;

	typedef struct packed {
		run_mode_t  mode;
		logic [2:0] last_code;
		logic       seen;
		logic [2:0] held_code;
		logic [15:0] ms;
		logic [2:0] step;
		cause_t     cause;
	} motor_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [hssc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [hssc_pkg::CFG_DATA_W-1:0] cfg_data;

	hssc_in_if  in_ch();
	hssc_out_if out_ch();

	hall_six_step_commutator dut (
		.clk(clk),
		.arst_n(arst_n),
		.hall_in(in_ch),
		.result(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	hssc_pkg::cfg_t regs_now = '{duty_cap: hssc_pkg::DUTY_CAP_RST, reverse_dir: 1'b0,
		kick_ms: hssc_pkg::KICK_MS_RST, stall_ms: hssc_pkg::STALL_MS_RST};
	motor_t motor = '{mode: MODE_IDLE, last_code: 3'd0, seen: 1'b0, held_code: 3'd0,
		ms: 16'd0, step: 3'd0, cause: CAUSE_NONE};
	hssc_pkg::res_t expected_results[$];

	int  mismatch_count = 0;
	int  samples_sent = 0;
	int  results_seen = 0;
	int  commutations = 0;
	int  sink_hold = 0;
	bit  src_idle_en = 1'b1;
	bit  sink_idle_en = 1'b1;
	bit  latch_allowed = 1'b0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hall code seen at each commutation step, forward order
	function automatic logic [2:0] code_at(input int pos);
		case (pos)
			0: return 3'd1;
			1: return 3'd3;
			2: return 3'd2;
			3: return 3'd6;
			4: return 3'd4;
			default: return 3'd5;
		endcase
	endfunction

	function automatic logic [2:0] step_for_code(input logic [2:0] code);
		logic [2:0] base;
		base = 3'd0;
		for (int k = 0; k < 6; k++)
			if (code_at(k) == code)
				base = k[2:0];
		if (regs_now.reverse_dir)
			base = 3'((base + 3) % 6);
		return base;
	endfunction

	function automatic logic [37:0] bridge_words(input logic [2:0] step);
		case (step)
			3'd0: return {27'h0030500, 11'h001};
			3'd1: return {27'h0030100, 11'h005};
			3'd2: return {27'h3000001, 11'h005};
			3'd3: return {27'h3000005, 11'h001};
			3'd4: return {27'h0000005, 11'h300};
			default: return {27'h0000500, 11'h300};
		endcase
	endfunction

	function automatic hssc_pkg::res_t advance_motor(input hssc_pkg::item_t s, inout motor_t m);
		hssc_pkg::res_t r;
		logic stable, legal, did;
		int duty;
		stable = m.seen && (s.hall_code == m.last_code);
		legal = (s.hall_code != HALL_ALL_LOW) && (s.hall_code != HALL_ALL_HIGH);
		did = 1'b0;
		m.last_code = s.hall_code;
		m.seen = 1'b1;
		case (m.mode)
			MODE_IDLE: begin
				if (s.bridge_fault) begin
					m.mode = MODE_LATCHED;
					m.cause = CAUSE_BRIDGE;
				end else if (stable) begin
					if (!legal) begin
						m.mode = MODE_LATCHED;
						m.cause = CAUSE_HALL;
					end else begin
						m.held_code = s.hall_code;
						m.step = step_for_code(s.hall_code);
						did = 1'b1;
						m.mode = MODE_KICK;
						m.ms = 16'd0;
					end
				end
			end
			MODE_KICK: begin
				if (s.ms_tick && m.ms != 16'hFFFF)
					m.ms++;
				if (m.ms >= regs_now.kick_ms) begin
					m.mode = MODE_RUN;
					m.ms = 16'd0;
				end
			end
			MODE_RUN: begin
				if (s.ms_tick && m.ms != 16'hFFFF)
					m.ms++;
				if (stable && !legal) begin
					m.mode = MODE_LATCHED;
					m.cause = CAUSE_HALL;
				end else begin
					if (stable && s.hall_code != m.held_code) begin
						m.held_code = s.hall_code;
						m.step = step_for_code(s.hall_code);
						did = 1'b1;
						m.ms = 16'd0;
					end
					if (m.ms > regs_now.stall_ms) begin
						m.mode = MODE_LATCHED;
						m.cause = CAUSE_STALL;
					end else if (s.bridge_fault) begin
						m.mode = MODE_LATCHED;
						m.cause = CAUSE_BRIDGE;
					end
				end
			end
			default: ;
		endcase
		if (m.mode == MODE_KICK || m.mode == MODE_RUN) begin
			duty = int'(regs_now.duty_cap);
			if (duty > hssc_pkg::PERIOD_TICKS_DEF)
				duty = hssc_pkg::PERIOD_TICKS_DEF;
			if (duty > (1 << hssc_pkg::TIMER_BITS_DEF) - 1)
				duty = (1 << hssc_pkg::TIMER_BITS_DEF) - 1;
			{r.gate_word_one, r.gate_word_two} = bridge_words(m.step);
			r.duty_ticks = duty[10:0];
		end else begin
			r.gate_word_one = '0;
			r.gate_word_two = '0;
			r.duty_ticks = '0;
		end
		r.drive_step = m.step;
		r.mode = m.mode;
		r.fault_cause = m.cause;
		r.commutated = did;
		return r;
	endfunction

	// While running, strip whatever would latch the block before the final phase
	function automatic hssc_pkg::item_t keep_alive(input hssc_pkg::item_t s);
		motor_t trial;
		hssc_pkg::item_t t;
		t = s;
		if (latch_allowed || motor.mode != MODE_RUN)
			return t;
		trial = motor;
		void'(advance_motor(t, trial));
		if (trial.mode == MODE_LATCHED) begin
			t.ms_tick = 1'b0;
			t.bridge_fault = 1'b0;
			trial = motor;
			void'(advance_motor(t, trial));
			if (trial.mode == MODE_LATCHED)
				t.hall_code = motor.held_code;
		end
		return t;
	endfunction

	task automatic send_sample(input hssc_pkg::item_t s);
		hssc_pkg::res_t want;
		while (src_idle_en && $urandom_range(99) < 16) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.hall_code <= s.hall_code;
		in_ch.bridge_fault <= s.bridge_fault;
		in_ch.ms_tick <= s.ms_tick;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		want = advance_motor(s, motor);
		if (want.commutated)
			commutations++;
		expected_results.push_back(want);
		samples_sent++;
	endtask

	task automatic send_fields(input logic [2:0] code, input logic fault, input logic tick);
		hssc_pkg::item_t s;
		s = '{hall_code: code, bridge_fault: fault, ms_tick: tick};
		send_sample(keep_alive(s));
	endtask

	task automatic wait_results_done();
		in_ch.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic program_regs(input hssc_pkg::cfg_t c, input logic [3:0] which);
		for (int i = 0; i < 4; i++) begin
			if (which[i]) begin
				cfg_we <= 1'b1;
				cfg_index <= hssc_pkg::reg_idx_t'(i);
				case (hssc_pkg::reg_idx_t'(i))
					hssc_pkg::REG_DUTY_CAP:    cfg_data <= 16'(c.duty_cap);
					hssc_pkg::REG_REVERSE_DIR: cfg_data <= 16'(c.reverse_dir);
					hssc_pkg::REG_KICK_MS:     cfg_data <= c.kick_ms;
					hssc_pkg::REG_STALL_MS:    cfg_data <= c.stall_ms;
				endcase
				@(posedge clk);
			end
		end
		cfg_we <= 1'b0;
		if (which[hssc_pkg::REG_DUTY_CAP])
			regs_now.duty_cap = c.duty_cap;
		if (which[hssc_pkg::REG_REVERSE_DIR])
			regs_now.reverse_dir = c.reverse_dir;
		if (which[hssc_pkg::REG_KICK_MS])
			regs_now.kick_ms = c.kick_ms;
		if (which[hssc_pkg::REG_STALL_MS])
			regs_now.stall_ms = c.stall_ms;
	endtask

	// Hall codes walked around the rotation, held for a few samples, with glitches
	task automatic run_rotation(input int count, input int tick_pct);
		int done, hold, pos, dir, roll;
		done = 0;
		dir = $urandom_range(1) ? 1 : 5;
		pos = $urandom_range(5);
		while (done < count) begin
			if ($urandom_range(99) < 10) begin
				send_fields(3'($urandom_range(7)), 1'b0, $urandom_range(99) < tick_pct);
				done++;
			end
			roll = $urandom_range(9);
			if (roll == 2)
				pos = $urandom_range(5);
			else if (roll > 2)
				pos = (pos + dir) % 6;
			hold = $urandom_range(1, 4);
			repeat (hold) begin
				send_fields(code_at(pos), 1'b0, $urandom_range(99) < tick_pct);
				done++;
			end
		end
	endtask

	task automatic test_idle_and_start();
		hssc_pkg::cfg_t c;
		logic [2:0] start_code;
		c = regs_now;
		c.kick_ms = 16'($urandom_range(2, 6));
		program_regs(c, 4'b0100);
		// no two equal samples in a row, so idle waits
		send_fields(3'd7, 1'b0, 1'b1);
		send_fields(3'd0, 1'b0, 1'b0);
		send_fields(3'd7, 1'b0, 1'b1);
		send_fields(3'd3, 1'b0, 1'b0);
		send_fields(3'd5, 1'b0, 1'b1);
		send_fields(3'd2, 1'b0, 1'b1);
		send_fields(3'd0, 1'b0, 1'b0);
		start_code = code_at($urandom_range(5));
		send_fields(start_code, 1'b0, 1'b0);
		send_fields(start_code, 1'b0, 1'b1);
	endtask

	// Hall and fault are ignored during kickstart
	task automatic test_kickstart_noise();
		while (motor.mode == MODE_KICK)
			send_fields(3'($urandom_range(7)), 1'($urandom_range(1)), 1'($urandom_range(1)));
	endtask

	task automatic test_rotation_sweep();
		hssc_pkg::cfg_t c;
		for (int seg = 0; seg < 10; seg++) begin
			wait_results_done();
			case (seg)
				0: begin
					c.duty_cap = 11'd0;
					c.reverse_dir = 1'b0;
					c.kick_ms = 16'd0;
					c.stall_ms = 16'd0;
				end
				1: begin
					c.duty_cap = 11'd2047;
					c.reverse_dir = 1'b1;
					c.kick_ms = 16'hFFFF;
					c.stall_ms = 16'hFFFF;
				end
				2: begin
					c.duty_cap = 11'(hssc_pkg::PERIOD_TICKS_DEF);
					c.reverse_dir = 1'b0;
					c.kick_ms = 16'($urandom_range(65535));
					c.stall_ms = 16'($urandom_range(1, 20));
				end
				default: begin
					c.duty_cap = ($urandom_range(3) == 0)
						? 11'(hssc_pkg::PERIOD_TICKS_DEF + $urandom_range(1))
						: 11'($urandom_range(2047));
					c.reverse_dir = 1'($urandom_range(1));
					c.kick_ms = 16'($urandom_range(65535));
					c.stall_ms = $urandom_range(1) ? 16'($urandom_range(60))
						: 16'($urandom_range(65535));
				end
			endcase
			if (c.stall_ms < motor.ms)
				c.stall_ms = motor.ms;
			program_regs(c, 4'hF);
			run_rotation($urandom_range(30, 60), $urandom_range(5, 95));
		end
	endtask

	task automatic test_full_rate();
		src_idle_en = 1'b0;
		sink_idle_en = 1'b0;
		run_rotation(100, 50);
		src_idle_en = 1'b1;
		sink_idle_en = 1'b1;
	endtask

	task automatic test_backpressure();
		src_idle_en = 1'b0;
		sink_hold = 80;
		run_rotation(30, 40);
		src_idle_en = 1'b1;
	endtask

	task automatic test_drain_pause();
		run_rotation(20, 30);
		wait_results_done();
		run_rotation(20, 30);
	endtask

	task automatic test_latch_and_hold();
		cause_t pick;
		hssc_pkg::cfg_t c;
		logic [2:0] bad_code;
		pick = cause_t'($urandom_range(1, 3));
		latch_allowed = 1'b1;
		case (pick)
			CAUSE_BRIDGE: send_fields(motor.held_code, 1'b1, 1'b0);
			CAUSE_HALL: begin
				bad_code = $urandom_range(1) ? HALL_ALL_HIGH : HALL_ALL_LOW;
				send_fields(bad_code, 1'b0, 1'b0);
				send_fields(bad_code, 1'b0, 1'b0);
			end
			default: begin
				wait_results_done();
				c = regs_now;
				c.stall_ms = 16'($urandom_range(3));
				program_regs(c, 4'b1000);
				while (motor.mode != MODE_LATCHED)
					send_fields(motor.held_code, 1'b0, 1'b1);
			end
		endcase
		repeat (40)
			send_fields(3'($urandom_range(7)), 1'($urandom_range(1)), 1'($urandom_range(1)));
	endtask

	task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, what, want, got);
			mismatch_count++;
		end
	endtask

	initial begin : result_monitor
		hssc_pkg::res_t want;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_ch.valid && out_ch.ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result transfer with nothing expected", $time);
					mismatch_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("gate_word_one", 32'(want.gate_word_one),
						32'(out_ch.gate_word_one));
					check_field("gate_word_two", 32'(want.gate_word_two),
						32'(out_ch.gate_word_two));
					check_field("duty_ticks", 32'(want.duty_ticks), 32'(out_ch.duty_ticks));
					check_field("drive_step", 32'(want.drive_step), 32'(out_ch.drive_step));
					check_field("mode", 32'(want.mode), 32'(out_ch.mode));
					check_field("fault_cause", 32'(want.fault_cause), 32'(out_ch.fault_cause));
					check_field("commutated", 32'(want.commutated), 32'(out_ch.commutated));
					results_seen++;
				end
			end
			if (sink_hold > 0) begin
				sink_hold--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= !(sink_idle_en && $urandom_range(99) < 16);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
		$display("tb_hall_six_step_commutator: FAIL");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= hssc_pkg::REG_DUTY_CAP;
		cfg_data <= '0;
		in_ch.valid <= 1'b0;
		in_ch.hall_code <= '0;
		in_ch.bridge_fault <= 1'b0;
		in_ch.ms_tick <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_and_start();
		test_kickstart_noise();
		test_rotation_sweep();
		test_full_rate();
		test_backpressure();
		test_drain_pause();
		test_latch_and_hold();

		wait_results_done();
		repeat (8) @(posedge clk);
		$display("%0d Hall samples sent, %0d results checked, %0d steps applied",
			samples_sent, results_seen, commutations);
		$display("start, kickstart, rotation under register sweeps, stalls; ended %s by %s",
			motor.mode.name(), motor.cause.name());
		if (mismatch_count == 0)
			$display("tb_hall_six_step_commutator: PASS");
		else
			$display("tb_hall_six_step_commutator: FAIL");
		$finish;
	end

endmodule

>>> hall_six_step_commutator.f
+incdir+src
src/hssc_pkg.sv
src/hssc_in_if.sv
src/hssc_out_if.sv
src/hssc_cfg.sv
src/hssc_core.sv
src/hall_six_step_commutator.sv
tb/sv/tb_hall_six_step_commutator.sv
